// File: hdl/glcv_pkg.sv
// ----------------------------------------------------------------------------
// glcv_pkg
// Shared constants and types for the Gaussian line convolver: kernel sizes,
// arithmetic widths, the command passed from front to back, and the result.
// ----------------------------------------------------------------------------
package glcv_pkg;

	localparam int MAX_RADIUS = 31;
	localparam int TAP_COUNT  = 2 * MAX_RADIUS + 1;
	localparam int TAP_AW     = 6;
	localparam int RAD_W      = 5;
	localparam int SMP_W      = 16;
	localparam int POS_W      = 16;
	localparam int PROD_W     = 2 * SMP_W;
	localparam int ACC_W      = PROD_W + 6;
	localparam int FRAC_W     = 15;
	localparam int RND_HALF   = 1 << (FRAC_W - 1);
	localparam int OUT_MAX    = 32767;
	localparam int OUT_MIN    = -32768;

	typedef enum logic [1:0] {
		CMD_TAP,
		CMD_SAMPLE,
		CMD_LAST
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                 kind;
		logic [TAP_AW-1:0]         tap_idx;
		logic signed [SMP_W-1:0]   data;
	} cmd_t;

	typedef struct packed {
		logic signed [SMP_W-1:0]   filtered;
		logic                      last_output;
	} res_t;

endpackage

// File: hdl/glcv_front.sv
// ----------------------------------------------------------------------------
// glcv_front
// Accepts input items, classifies them into tap loads, samples and line-final
// samples, drops out-of-range tap loads, and queues the commands for the back.
// ----------------------------------------------------------------------------
module glcv_front import glcv_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     mode,
	input  logic signed [SMP_W-1:0]  sample,
	input  logic                     line_end,
	input  logic [TAP_AW-1:0]        tap_index,
	input  logic signed [SMP_W-1:0]  tap_value,
	output logic                     cmd_valid,
	output cmd_t                     cmd,
	input  logic                     cmd_pop
);

	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);
	localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

	cmd_t              fifo_q [FQ_DEPTH];
	logic [FQ_AW-1:0]  wr_ptr_q;
	logic [FQ_AW-1:0]  rd_ptr_q;
	logic [FQ_CW-1:0]  count_q;
	logic              accept;
	logic              keep;
	logic              enq;
	logic              deq;
	cmd_t              cmd_in;

	assign full      = (count_q == FQ_CW'(FQ_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];

	assign accept = push && !full;
	// tap loads past the end of the kernel are dropped here
	assign keep   = !mode || (int'(tap_index) < TAP_COUNT);
	assign enq    = accept && keep;
	assign deq    = cmd_pop && cmd_valid;

	always_comb begin
		cmd_in.tap_idx = tap_index;
		if (mode) begin
			cmd_in.kind = CMD_TAP;
			cmd_in.data = tap_value;
		end else begin
			cmd_in.kind = line_end ? CMD_LAST : CMD_SAMPLE;
			cmd_in.data = sample;
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				count_q <= count_q + 1'b1;
			end else if (!enq && deq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/glcv_back.sv
// ----------------------------------------------------------------------------
// glcv_back
// Executes commands: stores kernel taps, keeps the sample window in a circular
// memory, and computes each output with one multiply-accumulate per cycle.
// ----------------------------------------------------------------------------
module glcv_back import glcv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RAD_W-1:0]  radius,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	output logic              res_push,
	output res_t              res,
	input  logic              res_full
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MAC,
		S_WAIT,
		S_PUSH
	} state_t;

	logic signed [SMP_W-1:0]   tap_mem [TAP_COUNT];
	logic signed [SMP_W-1:0]   win_mem [TAP_COUNT];

	state_t                    state_q;
	logic [TAP_COUNT-1:0]      tap_vld_q;
	logic [TAP_AW-1:0]         wp_q;
	logic [TAP_AW-1:0]         newest_q;
	logic [TAP_AW-1:0]         m_q;
	logic [TAP_AW-1:0]         m_end_q;
	logic [TAP_AW-1:0]         s_q;
	logic [TAP_AW-1:0]         s_end_q;
	logic [POS_W-1:0]          cnt_q;
	logic [POS_W-1:0]          pos_q;
	logic                      end_q;
	logic signed [ACC_W-1:0]   acc_q;

	logic signed [SMP_W-1:0]   tap_rd_s1;
	logic signed [SMP_W-1:0]   win_rd_s1;
	logic                      vld_s1;
	logic                      last_s1;
	logic                      tv_s1;
	logic                      wv_s1;
	logic signed [PROD_W-1:0]  prod_s2;
	logic                      vld_s2;
	logic                      last_s2;

	logic [RAD_W-1:0]          r_eff;
	logic [TAP_AW-1:0]         two_r;
	logic [TAP_AW-1:0]         first_s;
	logic [TAP_AW-1:0]         wp_next;
	logic [POS_W-1:0]          cnt_next;
	logic [TAP_AW-1:0]         lag;
	logic [TAP_AW:0]           addr_w;
	logic [TAP_AW-1:0]         rd_addr;
	logic                      issue;
	logic                      is_sample;
	logic                      tap_we;
	logic                      win_we;
	logic signed [SMP_W-1:0]   op_a;
	logic signed [SMP_W-1:0]   op_b;
	logic signed [ACC_W-1:0]   rnd;
	logic signed [ACC_W-FRAC_W-1:0] shr;

	assign r_eff    = (int'(radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius;
	assign two_r    = {r_eff, 1'b0};
	assign first_s  = (cnt_q >= POS_W'(r_eff)) ? '0
		: TAP_AW'(r_eff - cnt_q[RAD_W-1:0]);
	assign wp_next  = (wp_q == TAP_AW'(TAP_COUNT - 1)) ? '0 : wp_q + 1'b1;
	assign cnt_next = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

	// window lag j = m - s, newest sample at lag zero
	assign lag     = m_q - s_q;
	assign addr_w  = {1'b0, newest_q} - {1'b0, lag}
		+ ((newest_q < lag) ? (TAP_AW + 1)'(TAP_COUNT) : '0);
	assign rd_addr = addr_w[TAP_AW-1:0];

	assign issue     = (state_q == S_MAC);
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign is_sample = (cmd.kind == CMD_SAMPLE) || (cmd.kind == CMD_LAST);
	assign tap_we    = cmd_pop && (cmd.kind == CMD_TAP);
	assign win_we    = cmd_pop && is_sample;

	always_ff @(posedge clk) begin
		if (tap_we) begin
			tap_mem[cmd.tap_idx] <= cmd.data;
		end
		if (win_we) begin
			win_mem[wp_q] <= cmd.data;
		end
		tap_rd_s1 <= tap_mem[m_q];
		win_rd_s1 <= win_mem[rd_addr];
	end

	// never-written taps and samples older than the line read as zero
	assign op_a = tv_s1 ? tap_rd_s1 : '0;
	assign op_b = wv_s1 ? win_rd_s1 : '0;

	always_ff @(posedge clk) begin
		prod_s2 <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			tv_s1   <= 1'b0;
			wv_s1   <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= issue;
			last_s1 <= issue && (m_q == m_end_q);
			tv_s1   <= tap_vld_q[m_q];
			wv_s1   <= (POS_W'(lag) <= pos_q);
			vld_s2  <= vld_s1;
			last_s2 <= vld_s1 && last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			tap_vld_q <= '0;
			wp_q      <= '0;
			newest_q  <= '0;
			m_q       <= '0;
			m_end_q   <= '0;
			s_q       <= '0;
			s_end_q   <= '0;
			cnt_q     <= '0;
			pos_q     <= '0;
			end_q     <= 1'b0;
			acc_q     <= '0;
		end else begin
			if (vld_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.kind)
							CMD_TAP: begin
								tap_vld_q[cmd.tap_idx] <= 1'b1;
							end
							CMD_SAMPLE, CMD_LAST: begin
								newest_q <= wp_q;
								wp_q     <= wp_next;
								pos_q    <= cnt_q;
								cnt_q    <= cnt_next;
								end_q    <= (cmd.kind == CMD_LAST);
								m_end_q  <= two_r;
								acc_q    <= '0;
								if (cmd.kind == CMD_LAST) begin
									s_q     <= first_s;
									m_q     <= first_s;
									s_end_q <= TAP_AW'(r_eff);
									state_q <= S_MAC;
								end else if (cnt_q >= POS_W'(r_eff)) begin
									s_q     <= '0;
									m_q     <= '0;
									s_end_q <= '0;
									state_q <= S_MAC;
								end
							end
							default: ;
						endcase
					end
				end
				S_MAC: begin
					if (m_q == m_end_q) begin
						state_q <= S_WAIT;
					end else begin
						m_q <= m_q + 1'b1;
					end
				end
				S_WAIT: begin
					if (vld_s2 && last_s2) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (!res_full) begin
						if (s_q == s_end_q) begin
							state_q <= S_IDLE;
							if (end_q) begin
								cnt_q <= '0;
							end
						end else begin
							s_q     <= s_q + 1'b1;
							m_q     <= s_q + 1'b1;
							acc_q   <= '0;
							state_q <= S_MAC;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// round half up, then saturate to sixteen bits
	assign rnd = acc_q + ACC_W'(RND_HALF);
	assign shr = $signed(rnd[ACC_W-1:FRAC_W]);

	always_comb begin
		if (shr > (ACC_W - FRAC_W)'(OUT_MAX)) begin
			res.filtered = SMP_W'(OUT_MAX);
		end else if (shr < (ACC_W - FRAC_W)'(OUT_MIN)) begin
			res.filtered = SMP_W'(OUT_MIN);
		end else begin
			res.filtered = shr[SMP_W-1:0];
		end
		res.last_output = end_q && (s_q == s_end_q);
	end

	assign res_push = (state_q == S_PUSH) && !res_full;

endmodule

// File: hdl/glcv_outq.sv
// ----------------------------------------------------------------------------
// glcv_outq
// Two-entry result queue that lets the back keep working while a finished
// result waits to be taken.
// ----------------------------------------------------------------------------
module glcv_outq import glcv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  res_push,
	input  res_t  res,
	output logic  res_full,
	output logic  empty,
	input  logic  pop,
	output res_t  head
);

	localparam int OQ_DEPTH = 2;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	res_t              entry_q [OQ_DEPTH];
	logic [OQ_AW-1:0]  wr_ptr_q;
	logic [OQ_AW-1:0]  rd_ptr_q;
	logic [OQ_CW-1:0]  count_q;
	logic              enq;
	logic              deq;

	assign res_full = (count_q == OQ_CW'(OQ_DEPTH));
	assign empty    = (count_q == '0);
	assign head     = entry_q[rd_ptr_q];
	assign enq      = res_push && !res_full;
	assign deq      = pop && !empty;

	always_ff @(posedge clk) begin
		if (enq) begin
			entry_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				count_q <= count_q + 1'b1;
			end else if (!enq && deq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/gaussian_line_convolver_unit.sv
// ----------------------------------------------------------------------------
// gaussian_line_convolver_unit
// Flow: the back takes a command from the input queue only while idle. For a sample
//   it runs one multiply-accumulate per cycle over the taps, through a memory read
//   register and a product register, then pushes the result into the result queue;
//   a line-final sample repeats this for each result still owed. A tap load or a
//   sample without a result is consumed without any multiply-accumulate.
// Reset: queues empty, radius zero, line position zero, all kernel taps read as
//   zero through per-tap valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module gaussian_line_convolver_unit import glcv_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [RAD_W-1:0]         cfg_wdata,
	input  logic                     push,
	output logic                     full,
	input  logic                     mode,
	input  logic signed [SMP_W-1:0]  sample,
	input  logic                     line_end,
	input  logic [TAP_AW-1:0]        tap_index,
	input  logic signed [SMP_W-1:0]  tap_value,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [SMP_W-1:0]  filtered,
	output logic                     last_output
);

	logic [RAD_W-1:0]  radius_q;
	logic              cmd_valid;
	cmd_t              cmd;
	logic              cmd_pop;
	logic              res_push;
	res_t              res;
	logic              res_full;
	res_t              head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	glcv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.sample    (sample),
		.line_end  (line_end),
		.tap_index (tap_index),
		.tap_value (tap_value),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	glcv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.radius    (radius_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	glcv_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	assign filtered    = head.filtered;
	assign last_output = head.last_output;

endmodule

// File: hdl/glcv_checker.sv
// ----------------------------------------------------------------------------
// glcv_checker
// Port-level checks for the line convolver, attached to the top level by bind.
// ----------------------------------------------------------------------------
module glcv_checker import glcv_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic                     full,
	input  logic                     mode,
	input  logic                     line_end,
	input  logic                     empty,
	input  logic                     pop,
	input  logic signed [SMP_W-1:0]  filtered,
	input  logic                     last_output
);

	logic        seen_q;
	logic [3:0]  pending_q;
	logic        end_in;
	logic        last_out;

	assign end_in   = push && !full && !mode && line_end;
	assign last_out = pop && !empty && last_output;

	// tracks line-final samples taken versus line-final results handed out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			pending_q <= '0;
		end else begin
			if (push && !full && !mode) begin
				seen_q <= 1'b1;
			end
			if (end_in && !last_out) begin
				pending_q <= pending_q + 1'b1;
			end else if (!end_in && last_out) begin
				pending_q <= pending_q - 1'b1;
			end
		end
	end

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(filtered) && $stable(last_output)))
		else $error("waiting result changed before it was taken");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> empty)
		else $error("result offered before any sample transaction");

	a_last_matches_line: assert property (@(posedge clk) disable iff (!arst_n)
		last_out |-> (pending_q != '0))
		else $error("line-final result without a line-final sample");

	a_full_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("input queue filled without a push transaction");

endmodule

bind gaussian_line_convolver_unit glcv_checker u_glcv_checker (.*);

// File: test/gaussian_line_convolver_unit_test.sv
// ----------------------------------------------------------------------------
// gaussian_line_convolver_unit_test
// Self-checking bench for the line convolver. Taps and samples go in through
// the push side, and every popped result is checked against a line-filter
// predictor kept in a small scoreboard. The directed part covers saturation,
// rounding, short lines, out-of-range and unused taps, and the widest radius.
// Random phases then change the radius, reload kernels and stream lines of
// random length with random gaps. A long receiver hold backs up the input.
// ----------------------------------------------------------------------------
module gaussian_line_convolver_unit_test import glcv_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam bit MODE_SAMPLE    = 1'b0;
	localparam bit MODE_TAP       = 1'b1;
	localparam int RANDOM_ITEMS   = 270;
	localparam int SETTLE_CYCLES  = 200;
	localparam int HOLD_CYCLES    = 600;
	localparam int CYCLE_LIMIT    = 6000000;

	class line_filter_board;
		logic signed [SMP_W-1:0] window [TAP_COUNT];
		logic signed [SMP_W-1:0] taps [TAP_COUNT];
		int unsigned line_pos;
		logic [RAD_W-1:0] radius;
		res_t pending_outputs [$];
		int mismatches;

		function new();
			foreach (window[i]) begin
				window[i] = '0;
				taps[i] = '0;
			end
			line_pos = 0;
			radius = '0;
			mismatches = 0;
		endfunction

		function void set_radius(logic [RAD_W-1:0] r);
			radius = r;
		endfunction

		function int pending_count();
			return pending_outputs.size();
		endfunction

		// output whose newest needed sample lies shift places past the newest one held
		function logic signed [SMP_W-1:0] convolve_at(int shift, int r);
			longint acc;
			longint q;
			acc = 0;
			for (int m = shift; m <= 2 * r; m++)
				acc += longint'(taps[m]) * longint'(window[m - shift]);
			q = (acc + RND_HALF) >>> FRAC_W;
			if (q > OUT_MAX)
				q = OUT_MAX;
			else if (q < OUT_MIN)
				q = OUT_MIN;
			return q[SMP_W-1:0];
		endfunction

		function void take_item(bit m, logic signed [SMP_W-1:0] smp, bit le,
				logic [TAP_AW-1:0] idx, logic signed [SMP_W-1:0] val);
			int r;
			int first;
			int unsigned pos;
			res_t item;
			if (m == MODE_TAP) begin
				if (idx < TAP_COUNT)
					taps[idx] = val;
				return;
			end
			r = (radius > MAX_RADIUS) ? MAX_RADIUS : int'(radius);
			for (int d = TAP_COUNT - 1; d > 0; d--)
				window[d] = window[d - 1];
			window[0] = smp;
			pos = line_pos;
			if (line_pos < 16'hFFFF)
				line_pos++;
			if (!le) begin
				if (pos >= r) begin
					item.filtered = convolve_at(0, r);
					item.last_output = 1'b0;
					pending_outputs.push_back(item);
				end
				return;
			end
			// line end flushes the outputs still owed, with zeros past the end
			first = (pos >= r) ? 0 : r - int'(pos);
			for (int s = first; s <= r; s++) begin
				item.filtered = convolve_at(s, r);
				item.last_output = (s == r);
				pending_outputs.push_back(item);
			end
			foreach (window[i])
				window[i] = '0;
			line_pos = 0;
		endfunction

		function void compare_output(logic signed [SMP_W-1:0] filt, logic is_last);
			res_t want;
			if (pending_outputs.size() == 0) begin
				$display("%0t: result with nothing expected: filtered %0d last_output %0b",
					$time, filt, is_last);
				mismatches++;
				return;
			end
			want = pending_outputs.pop_front();
			if (filt !== want.filtered) begin
				$display("%0t: filtered mismatch: expected %0d actual %0d",
					$time, want.filtered, filt);
				mismatches++;
			end
			if (is_last !== want.last_output) begin
				$display("%0t: last_output mismatch: expected %0b actual %0b",
					$time, want.last_output, is_last);
				mismatches++;
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [RAD_W-1:0]         cfg_wdata;
	logic                     push;
	logic                     full;
	logic                     mode;
	logic signed [SMP_W-1:0]  sample;
	logic                     line_end;
	logic [TAP_AW-1:0]        tap_index;
	logic signed [SMP_W-1:0]  tap_value;
	logic                     empty;
	logic                     pop;
	logic signed [SMP_W-1:0]  filtered;
	logic                     last_output;

	line_filter_board board = new();
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	int items_sent = 0;
	int cur_radius = 0;

	gaussian_line_convolver_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.sample      (sample),
		.line_end    (line_end),
		.tap_index   (tap_index),
		.tap_value   (tap_value),
		.empty       (empty),
		.pop         (pop),
		.filtered    (filtered),
		.last_output (last_output)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// one transaction per task call; returns at the falling edge after acceptance
	task automatic send_item(bit m, logic signed [SMP_W-1:0] smp, bit le,
			logic [TAP_AW-1:0] idx, logic signed [SMP_W-1:0] val);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		mode <= m;
		sample <= smp;
		line_end <= le;
		tap_index <= idx;
		tap_value <= val;
		do
			@(posedge clk);
		while (full);
		board.take_item(m, smp, le, idx, val);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic load_tap(logic [TAP_AW-1:0] idx, logic signed [SMP_W-1:0] val);
		send_item(MODE_TAP, SMP_W'($urandom), 1'($urandom), idx, val);
	endtask

	task automatic feed_sample(logic signed [SMP_W-1:0] smp, bit le);
		send_item(MODE_SAMPLE, smp, le, TAP_AW'($urandom), SMP_W'($urandom));
	endtask

	task automatic wait_until_idle();
		push <= 1'b0;
		while (board.pending_count() != 0)
			@(negedge clk);
		// tap loads and short-line samples may still sit in the block
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_radius(int r);
		wait_until_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= RAD_W'(r);
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_radius(RAD_W'(r));
		cur_radius = r;
	endtask

	function automatic logic signed [SMP_W-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return SMP_W'(OUT_MAX);
			1: return SMP_W'(OUT_MIN);
			2: return SMP_W'(int'($urandom_range(0, 127)) - 64);
			default: return SMP_W'($urandom);
		endcase
	endfunction

	// shapes: full-range noise, small noise, bell, first derivative of a bell
	task automatic load_kernel(int r, int shape);
		int d;
		int v;
		for (int m = 0; m <= 2 * r; m++) begin
			d = m - r;
			case (shape)
				0: v = int'($urandom);
				1: v = int'($urandom_range(0, 4095)) - 2048;
				2: v = 16384 / (1 + d * d);
				default: v = (8192 * d) / (1 + d * d);
			endcase
			load_tap(TAP_AW'(m), SMP_W'(v));
		end
		if ($urandom_range(0, 1) == 0)
			load_tap(TAP_AW'(TAP_COUNT), SMP_W'($urandom));
		if (r < MAX_RADIUS && $urandom_range(0, 1) == 0)
			load_tap(TAP_AW'($urandom_range(2 * r + 1, TAP_COUNT - 1)), SMP_W'($urandom));
	endtask

	task automatic feed_line(int len, bit closed);
		for (int k = 0; k < len; k++) begin
			// a tap load mid-line must leave the line alone
			if (!quiet && $urandom_range(0, 11) == 0)
				load_tap(TAP_AW'($urandom_range(0, TAP_COUNT)),
					SMP_W'(int'($urandom_range(0, 4095)) - 2048));
			feed_sample(rand_sample(), closed && (k == len - 1));
		end
	endtask

	task automatic run_directed();
		write_radius(0);
		load_tap(TAP_AW'(0), SMP_W'(OUT_MAX));
		load_tap(TAP_AW'(TAP_COUNT), SMP_W'(OUT_MIN));
		load_tap(TAP_AW'(TAP_COUNT - 1), -16'sd1);
		feed_sample(SMP_W'(OUT_MAX), 1'b0);
		feed_sample(SMP_W'(OUT_MIN), 1'b0);
		feed_sample('0, 1'b0);
		feed_sample(-16'sd1, 1'b1);
		feed_sample(16'sd12345, 1'b1);

		// full negative taps on full negative samples must clip high
		write_radius(2);
		for (int m = 0; m < 5; m++)
			load_tap(TAP_AW'(m), SMP_W'(OUT_MIN));
		feed_sample(SMP_W'(OUT_MIN), 1'b0);
		feed_sample(SMP_W'(OUT_MIN), 1'b0);
		feed_sample(16'sd1, 1'b1);
		feed_sample(16'sd100, 1'b1);

		// halves round toward plus infinity
		write_radius(0);
		load_tap(TAP_AW'(0), 16'sd16384);
		feed_sample(16'sd1, 1'b0);
		feed_sample(-16'sd1, 1'b0);
		feed_sample(16'sd3, 1'b1);

		// widest kernel; a one-sample line flushes a single result
		write_radius(MAX_RADIUS);
		load_tap(TAP_AW'(TAP_COUNT - 1), SMP_W'(OUT_MAX));
		load_tap(TAP_AW'(0), SMP_W'(OUT_MIN));
		feed_sample(SMP_W'(OUT_MAX), 1'b1);
	endtask

	task automatic run_random();
		int base;
		int lines;
		int len;
		int r;
		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 7))
					0: r = 0;
					1: r = MAX_RADIUS;
					2: r = $urandom_range(9, MAX_RADIUS - 1);
					default: r = $urandom_range(1, 8);
				endcase
				write_radius(r);
			end
			quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1) == 0)
				load_kernel(cur_radius, $urandom_range(0, 3));
			lines = $urandom_range(1, 3);
			for (int i = 0; i < lines; i++) begin
				if ($urandom_range(0, 4) == 0)
					len = $urandom_range(1, 3);
				else
					len = $urandom_range(1, 2 * cur_radius + 8);
				// an open line may carry over into a radius change
				feed_line(len, !(i == lines - 1 && $urandom_range(0, 4) == 0));
			end
		end
		quiet = 1'b0;
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		push = 1'b0;
		mode = 1'b0;
		sample = '0;
		line_end = 1'b0;
		tap_index = '0;
		tap_value = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();

		// receiver stalls while samples keep coming, so the block backs up
		write_radius(2);
		load_kernel(2, 1);
		quiet = 1'b1;
		hold_req = 1'b1;
		feed_line(150, 1'b1);
		quiet = 1'b0;

		run_random();

		wait_until_idle();
		if (board.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : result_drain
		int gap;
		int hold_left;
		pop = 1'b0;
		gap = 0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				board.compare_output(filtered, last_output);
				gap = quiet ? 0 : $urandom_range(0, 15);
			end
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (gap > 0) begin
				pop <= 1'b0;
				gap--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout after %0d cycles", $time, cycles);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
hdl/glcv_pkg.sv
hdl/glcv_front.sv
hdl/glcv_back.sv
hdl/glcv_outq.sv
hdl/gaussian_line_convolver_unit.sv
hdl/glcv_checker.sv
test/gaussian_line_convolver_unit_test.sv
